// ----- rtl/core/lfuacl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package lfuacl_pkg;

	localparam int ADDR_W    = 32;
	localparam int TIME_W    = 32;
	localparam int SLOT_W    = 4;
	localparam int BSL_W     = 5;
	localparam logic [BSL_W-1:0] BSL_RESET = 5'd6;

	typedef struct packed {
		logic capture;
		logic lookup;
		logic scan;
		logic commit;
	} lfuacl_cmd_t;

	typedef struct packed {
		logic found;
		logic scan_last;
	} lfuacl_sts_t;

endpackage
`default_nettype wire

// ----- rtl/core/lfuacl_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lfuacl_ctrl (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	output logic                    in_stall,
	output logic                    out_valid,
	input  wire                     out_stall,
	input  lfuacl_pkg::lfuacl_sts_t sts,
	output lfuacl_pkg::lfuacl_cmd_t cmd
);
	import lfuacl_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_SCAN,
		ST_COMMIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   commit_ok;

	always_comb begin
		commit_ok   = !(out_valid_q && out_stall);
		cmd.capture = (state_q == ST_IDLE) && in_valid;
		cmd.lookup  = (state_q == ST_LOOK);
		cmd.scan    = (state_q == ST_SCAN);
		cmd.commit  = (state_q == ST_COMMIT) && commit_ok;
		in_stall    = (state_q != ST_IDLE);
		out_valid   = out_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					state_q <= sts.found ? ST_COMMIT : ST_SCAN;
				end
				ST_SCAN: begin
					if (sts.scan_last) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					if (commit_ok) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/lfuacl_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lfuacl_dp #(
	parameter int ENTRIES      = 16,
	parameter int HISTORY_BITS = 9
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire  [lfuacl_pkg::BSL_W-1:0]     block_size_log2,
	input  wire  [lfuacl_pkg::ADDR_W-1:0]    address,
	input  wire  [lfuacl_pkg::TIME_W-1:0]    access_time,
	input  lfuacl_pkg::lfuacl_cmd_t          cmd,
	output lfuacl_pkg::lfuacl_sts_t          sts,
	output logic                             hit,
	output logic [lfuacl_pkg::SLOT_W-1:0]    slot,
	output logic                             evicted
);
	import lfuacl_pkg::*;

	localparam int IW = $clog2(ENTRIES);
	localparam int CW = $clog2(HISTORY_BITS + 1);

	function automatic logic [CW-1:0] count_ones(input logic [HISTORY_BITS-1:0] v);
		logic [CW-1:0] n;
		n = '0;
		for (int b = 0; b < HISTORY_BITS; b++) begin
			n = n + CW'(v[b]);
		end
		return n;
	endfunction

	logic [BSL_W-1:0]        bsl_q;
	logic [ENTRIES-1:0]      entry_valid_q;
	logic [HISTORY_BITS-1:0] use_hist_q [ENTRIES];
	logic [ADDR_W-1:0]       entry_tag_q [ENTRIES];
	logic [TIME_W-1:0]       entry_time_q [ENTRIES];

	logic [ADDR_W-1:0]       tag_q;
	logic [TIME_W-1:0]       now_q;
	logic [IW-1:0]           res_idx_q;
	logic                    res_hit_q;
	logic                    res_evict_q;
	logic [IW-1:0]           scan_idx_q;
	logic [CW-1:0]           best_q;
	logic [TIME_W-1:0]       best_time_q;
	logic                    hit_q;
	logic [SLOT_W-1:0]       slot_q;
	logic                    evicted_q;

	logic [ENTRIES-1:0]      cand;
	logic                    found_c;
	logic [IW-1:0]           sel_c;
	logic [CW-1:0]           ones_c;
	logic [TIME_W-1:0]       scan_time_c;
	logic [SLOT_W+IW-1:0]    slot_ext;

	always_comb begin
		found_c = 1'b0;
		sel_c   = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			cand[i] = !entry_valid_q[i] || (entry_tag_q[i] == tag_q);
		end
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (cand[i]) begin
				found_c = 1'b1;
				sel_c   = IW'(i);
			end
		end
		ones_c      = count_ones(use_hist_q[scan_idx_q]);
		scan_time_c = entry_time_q[scan_idx_q];
		slot_ext    = {{SLOT_W{1'b0}}, res_idx_q};
	end

	assign sts.found     = found_c;
	assign sts.scan_last = (scan_idx_q == IW'(ENTRIES - 1));
	assign hit           = hit_q;
	assign slot          = slot_q;
	assign evicted       = evicted_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bsl_q         <= BSL_RESET;
			entry_valid_q <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				use_hist_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				bsl_q <= block_size_log2;
			end
			// age every history on each access
			if (cmd.lookup) begin
				for (int i = 0; i < ENTRIES; i++) begin
					use_hist_q[i] <= {use_hist_q[i][HISTORY_BITS-2:0], 1'b0};
				end
			end
			if (cmd.commit) begin
				entry_valid_q[res_idx_q] <= 1'b1;
				if (res_hit_q) begin
					use_hist_q[res_idx_q][0] <= 1'b1;
				end else begin
					use_hist_q[res_idx_q] <= HISTORY_BITS'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			tag_q <= address >> bsl_q;
			now_q <= access_time;
		end
		if (cmd.lookup) begin
			res_idx_q   <= sel_c;
			res_hit_q   <= found_c && entry_valid_q[sel_c];
			res_evict_q <= !found_c;
			scan_idx_q  <= '0;
			best_q      <= CW'(HISTORY_BITS);
			best_time_q <= entry_time_q[0];
		end
		// pick the fewest ones, then the strictly older time, then the lower index
		if (cmd.scan) begin
			scan_idx_q <= scan_idx_q + IW'(1);
			if (ones_c == best_q) begin
				if (scan_time_c < best_time_q) begin
					res_idx_q   <= scan_idx_q;
					best_time_q <= scan_time_c;
				end
			end else if (ones_c < best_q) begin
				res_idx_q   <= scan_idx_q;
				best_q      <= ones_c;
				best_time_q <= scan_time_c;
			end
		end
		if (cmd.commit) begin
			entry_time_q[res_idx_q] <= now_q;
			if (!res_hit_q) begin
				entry_tag_q[res_idx_q] <= tag_q;
			end
			hit_q     <= res_hit_q;
			slot_q    <= slot_ext[SLOT_W-1:0];
			evicted_q <= res_evict_q;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/lfu_aging_cache_lookup.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Fully associative tag store of ENTRIES entries with aging least-frequently-used
// replacement. Each item gives a byte address and a timestamp and yields one result:
// hit, the slot hit, filled or replaced, and whether a valid entry was evicted.
// A hit or a fill of a free entry runs capture, parallel tag compare with history
// aging and commit, the last of which loads the result register. A miss on a full
// store then adds a victim scan over all ENTRIES entries, which checks one history
// popcount and one time compare per cycle. One item is in flight at a time; the
// result register lets the next item be accepted while the previous result is
// still stalled. block_size_log2 may be written at any time the block is idle.
module lfu_aging_cache_lookup #(
	parameter int ENTRIES      = 16,
	parameter int HISTORY_BITS = 9
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_valid,
	output logic                          cfg_ready,
	input  wire  [lfuacl_pkg::BSL_W-1:0]  block_size_log2,
	input  wire                           in_valid,
	output logic                          in_stall,
	input  wire  [lfuacl_pkg::ADDR_W-1:0] address,
	input  wire  [lfuacl_pkg::TIME_W-1:0] access_time,
	output logic                          out_valid,
	input  wire                           out_stall,
	output logic                          hit,
	output logic [lfuacl_pkg::SLOT_W-1:0] slot,
	output logic                          evicted
);
	import lfuacl_pkg::*;

	lfuacl_cmd_t cmd;
	lfuacl_sts_t sts;

	assign cfg_ready = 1'b1;

	lfuacl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	lfuacl_dp #(
		.ENTRIES      (ENTRIES),
		.HISTORY_BITS (HISTORY_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_valid && cfg_ready),
		.block_size_log2 (block_size_log2),
		.address         (address),
		.access_time     (access_time),
		.cmd             (cmd),
		.sts             (sts),
		.hit             (hit),
		.slot            (slot),
		.evicted         (evicted)
	);

endmodule
`default_nettype wire
